/* sv/crp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command ring producer package
// Result kinds, the result beat type and the fixed ring constants.
// ----------------------------------------------------------------------------
package crp_pkg;

  typedef enum logic [1:0] {
    KindCmd  = 2'd0,
    KindLink = 2'd1,
    KindFull = 2'd2,
    KindDone = 2'd3
  } kind_e;

  // Configuration register indexes
  localparam logic [1:0] RegBase  = 2'd0;
  localparam logic [1:0] RegSlots = 2'd1;

  // Slot count clamp: never below 2, never above MaxSlots or 256
  localparam int unsigned MaxSlots = 256;
  localparam logic [8:0]  SlotMin  = 9'd2;
  localparam logic [8:0]  SlotCap  = (MaxSlots > 256) ? 9'd256 : 9'(MaxSlots);
  localparam logic [8:0]  SlotRst  = 9'd256;

  // Link TRB control: type 6, toggle cycle set; bit 0 gets the producer cycle
  localparam logic [31:0] LinkControl = 32'h0000_1802;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] address;
    logic [63:0] parameter_w;
    logic [31:0] status;
    logic [31:0] control;
    logic [7:0]  slot;
    logic [8:0]  dequeue;
    logic        pcycle;
    logic        last;
  } beat_t;

endpackage

/* sv/command_ring_producer_unit.sv */
`timescale 1ns / 1ps
// Result beats are registered in the result queue when their item is accepted and leave it in order.
// Throughput: one item per cycle while in_stall_o is low; a wrap adds a link beat,
//   and the single output port drains one beat per cycle, so the four-entry result queue sets the pace.
// in_stall_o is high while fewer than two queue entries are free.
// Reset (rst_ni low, asynchronous): enqueue index 0, dequeue position 0, both
//   cycle bits 1, ring base 0, slot count 256, result queue empty.
// ----------------------------------------------------------------------------
// Command ring producer
// Enqueues command TRBs on a cycle-bit ring, emits link writes on wrap and
// tracks the dequeue position from completion events.
// ----------------------------------------------------------------------------
module command_ring_producer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [63:0] trb_parameter_i,
  input  logic [31:0] trb_status_i,
  input  logic [31:0] trb_control_i,
  input  logic [63:0] completed_pointer_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output crp_pkg::kind_e result_kind_o,
  output logic [63:0] write_address_o,
  output logic [63:0] write_parameter_o,
  output logic [31:0] write_status_o,
  output logic [31:0] write_control_o,
  output logic [7:0]  slot_index_o,
  output logic [8:0]  dequeue_index_o,
  output logic        producer_cycle_o,
  output logic        last_o
);
  import crp_pkg::*;

  // configuration registers
  logic [63:0] base_q;
  logic [8:0]  slots_q;

  // ring state
  logic [7:0]  enq_idx_q, enq_idx_d;
  logic [8:0]  deq_pos_q, deq_pos_d;
  logic        pcs_q, pcs_d;
  logic        ccs_q, ccs_d;

  // result queue
  beat_t       fifo_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q;

  logic        in_acc, out_acc;
  logic [1:0]  push_cnt;
  beat_t       beat0, beat1;

  logic [8:0]  slot_total, link_slot, next_slot, new_deq;
  logic [63:0] ptr_off;
  logic        room_ok;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (count_q > 3'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      slots_q <= SlotRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegBase:  base_q  <= cfg_data_i;
        RegSlots: slots_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slots_q < SlotMin) begin
      slot_total = SlotMin;
    end else if (slots_q > SlotCap) begin
      slot_total = SlotCap;
    end else begin
      slot_total = slots_q;
    end
  end

  assign link_slot = slot_total - 9'd1;
  assign next_slot = {1'b0, enq_idx_q} + 9'd1;
  assign ptr_off   = completed_pointer_i - base_q;
  assign new_deq   = ptr_off[12:4] + 9'd1;

  // ring full test on cycle bits and indices
  assign room_ok = (ccs_q == pcs_q) ? ({1'b0, enq_idx_q} >= deq_pos_q)
                                    : ({1'b0, enq_idx_q} <  deq_pos_q);

  always_comb begin
    enq_idx_d = enq_idx_q;
    deq_pos_d = deq_pos_q;
    pcs_d     = pcs_q;
    ccs_d     = ccs_q;
    push_cnt  = 2'd0;

    beat0             = '0;
    beat0.slot        = enq_idx_q;
    beat0.dequeue     = deq_pos_q;
    beat0.pcycle      = pcs_q;
    beat0.last        = 1'b1;
    beat1             = '0;
    beat1.kind        = KindLink;
    beat1.address     = base_q + {52'd0, link_slot[7:0], 4'd0};
    beat1.parameter_w = base_q;
    beat1.control     = LinkControl | {31'd0, pcs_q};
    beat1.slot        = link_slot[7:0];
    beat1.dequeue     = deq_pos_q;
    beat1.pcycle      = !pcs_q;
    beat1.last        = 1'b1;

    if (in_acc) begin
      push_cnt = 2'd1;
      if (req_type_i) begin
        // completion: toggle consumer cycle when the position moves back
        deq_pos_d     = new_deq;
        ccs_d         = (new_deq < deq_pos_q) ? !ccs_q : ccs_q;
        beat0.kind    = KindDone;
        beat0.dequeue = new_deq;
      end else if (!room_ok) begin
        beat0.kind = KindFull;
      end else begin
        beat0.kind        = KindCmd;
        beat0.address     = base_q + {52'd0, enq_idx_q, 4'd0};
        beat0.parameter_w = trb_parameter_i;
        beat0.status      = trb_status_i;
        beat0.control     = {trb_control_i[31:1], pcs_q};
        if (next_slot >= link_slot) begin
          // wrap: follow with the link beat and flip the producer cycle
          enq_idx_d    = '0;
          pcs_d        = !pcs_q;
          beat0.slot   = enq_idx_q;
          beat0.pcycle = !pcs_q;
          beat0.last   = 1'b0;
          push_cnt     = 2'd2;
        end else begin
          enq_idx_d = next_slot[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enq_idx_q <= '0;
      deq_pos_q <= '0;
      pcs_q     <= 1'b1;
      ccs_q     <= 1'b1;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      count_q   <= '0;
    end else begin
      enq_idx_q <= enq_idx_d;
      deq_pos_q <= deq_pos_d;
      pcs_q     <= pcs_d;
      ccs_q     <= ccs_d;
      wr_ptr_q  <= wr_ptr_q + push_cnt;
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + {1'b0, push_cnt} - {2'd0, out_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      fifo_q[wr_ptr_q] <= beat0;
    end
    if (push_cnt == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= beat1;
    end
  end

  beat_t head;
  assign head              = fifo_q[rd_ptr_q];
  assign result_kind_o     = head.kind;
  assign write_address_o   = head.address;
  assign write_parameter_o = head.parameter_w;
  assign write_status_o    = head.status;
  assign write_control_o   = head.control;
  assign slot_index_o      = head.slot;
  assign dequeue_index_o   = head.dequeue;
  assign producer_cycle_o  = head.pcycle;
  assign last_o            = head.last;

endmodule

/* sv/crp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command ring producer checker
// Port-level checks on result beats, attached to the top level by bind.
// ----------------------------------------------------------------------------
module crp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input crp_pkg::kind_e result_kind_o,
  input logic [63:0] write_address_o,
  input logic [31:0] write_control_o,
  input logic        producer_cycle_o,
  input logic        last_o
);
  import crp_pkg::*;

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(write_address_o)
      && $stable(result_kind_o) && $stable(last_o))
    else $error("stalled result beat changed");

  // a command beat that is not last is followed at once by its link beat
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && result_kind_o == KindCmd && !last_o
      |=> out_valid_o && result_kind_o == KindLink && last_o)
    else $error("wrap command beat not followed by link beat");

  // link beat carries the old producer cycle; the reported cycle is toggled
  a_link_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindLink
      |-> write_control_o[0] != producer_cycle_o)
    else $error("link beat cycle bit does not match toggled producer cycle");

  // refused and completion beats write nothing and end the item
  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KindFull || result_kind_o == KindDone)
      |-> last_o && write_address_o == 64'd0 && write_control_o == 32'd0)
    else $error("non-write beat carries write data");

endmodule

bind command_ring_producer_unit crp_checker u_crp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .result_kind_o    (result_kind_o),
  .write_address_o  (write_address_o),
  .write_control_o  (write_control_o),
  .producer_cycle_o (producer_cycle_o),
  .last_o           (last_o)
);
